@@ hw/rtl/nbrs_pkg.sv @@
// Package for the nine-byte rejection sampler: state and result types,
// register map and fixed constants. No dependencies.
`default_nettype none

package nbrs_pkg;

    // Widths fixed by the item fields
    localparam int BYTE_W     = 8;
    localparam int COEFF_W    = 9;
    localparam int INDEX_W    = 10;
    localparam int MODULUS_W  = 10;
    localparam int COUNT_W    = 11;
    localparam int POS_W      = 4;

    // Upper bound on the number of coefficients in one run
    localparam int MAX_COEFFS = 1024;

    // Last candidate byte position inside a nine-byte group
    localparam logic [POS_W-1:0] GROUP_LAST = 4'd8;

    // Configuration register map (byte address 4*i)
    localparam int PADDR_W = 3;
    typedef enum logic [0:0] {
        REG_MODULUS = 1'b0,
        REG_WANTED  = 1'b1
    } reg_index_t;

    localparam logic [MODULUS_W-1:0] MODULUS_RESET = 10'd512;
    localparam logic [COUNT_W-1:0]   WANTED_RESET  = 11'd512;

    typedef struct packed {
        logic [BYTE_W-1:0]  low_bit_byte;
        logic [POS_W-1:0]   group_position;
        logic [COUNT_W-1:0] accepted_count;
    } sampler_state_t;

    typedef struct packed {
        logic               valid;
        logic [COEFF_W-1:0] coefficient;
        logic [INDEX_W-1:0] coeff_index;
        logic               final_res;
    } sample_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/nbrs_if.sv @@
// Valid/ready channel interfaces for the sampler's byte input and
// coefficient output. Depends on nbrs_pkg.
`default_nettype none

interface nbrs_in_if
    import nbrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rand_byte;
    logic              restart;

    modport source (output valid, output rand_byte, output restart, input ready);
    modport sink   (input valid, input rand_byte, input restart, output ready);
endinterface

interface nbrs_out_if
    import nbrs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COEFF_W-1:0] coefficient;
    logic [INDEX_W-1:0] coeff_index;
    logic               final_res;

    modport source (output valid, output coefficient, output coeff_index,
                    output final_res, input ready);
    modport sink   (input valid, input coefficient, input coeff_index,
                    input final_res, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/nine_bit_rejection_sampler.sv @@
// Top level of the nine-byte rejection sampler: APB registers, input
// register, step logic and result register. Depends on nbrs_pkg, nbrs_if, nbrs_step.
//
//  channel   dir  payload                                 transfer when
//  -------   ---  --------------------------------------  ---------------------
//  in_ch     in   rand_byte[7:0], restart                 valid && ready
//  out_ch    out  coefficient[8:0], coeff_index[9:0],     valid && ready
//                 final_res
//  apb       in   modulus @0x0 (10b), wanted_count @0x4   psel&penable&pwrite
//
//  One byte per cycle while the output is not stalled; a byte passes from input
//  transfer to result through the input register, then step logic into the result register.
//  The step reads and writes the sampler state in the same cycle, which sets the rate.
//  rst_n clears state, valid flags and registers to their defaults at once.
//  A stalled output holds the result; the input register keeps taking a
//  byte whenever it is empty or the result register is free or draining.
`default_nettype none

module nine_bit_rejection_sampler
    import nbrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    nbrs_in_if.sink                 in_ch,
    nbrs_out_if.source              out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // ---------------- configuration registers ----------------
    logic [MODULUS_W-1:0] modulus_reg;
    logic [COUNT_W-1:0]   wanted_reg;
    logic                 cfg_write;
    reg_index_t           cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            wanted_reg  <= WANTED_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_MODULUS: modulus_reg <= pwdata[MODULUS_W-1:0];
                REG_WANTED:  wanted_reg  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_MODULUS: prdata = {22'd0, modulus_reg};
            REG_WANTED:  prdata = {21'd0, wanted_reg};
            default:     prdata = '0;
        endcase
    end

    // effective wanted count, clamped to the run limit
    logic [COUNT_W-1:0] want;
    assign want = ({2'b00, wanted_reg} > 13'(MAX_COEFFS)) ? COUNT_W'(MAX_COEFFS)
                                                          : wanted_reg;

    // ---------------- input register ----------------
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_restart_reg;
    logic              out_valid_reg;
    logic              advance;

    // step fires when the result register is free or draining this cycle
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg    <= in_ch.rand_byte;
            s1_restart_reg <= in_ch.restart;
        end
    end

    // ---------------- sampler state and step ----------------
    sampler_state_t state_reg;
    sampler_state_t state_next;
    sample_result_t step_res;

    nbrs_step u_step (
        .state      (state_reg),
        .rand_byte  (s1_byte_reg),
        .restart    (s1_restart_reg),
        .modulus    (modulus_reg),
        .want       (want),
        .state_next (state_next),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- result register ----------------
    logic               out_valid_next;
    logic [COEFF_W-1:0] coeff_reg;
    logic [INDEX_W-1:0] index_reg;
    logic               final_reg;

    always_comb
    begin
        if (advance)
            out_valid_next = step_res.valid;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.valid)
        begin
            coeff_reg <= step_res.coefficient;
            index_reg <= step_res.coeff_index;
            final_reg <= step_res.final_res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.coefficient = coeff_reg;
    assign out_ch.coeff_index = index_reg;
    assign out_ch.final_res   = final_reg;

    // ---------------- assertions ----------------
    // a held result always passed the modulus compare
    a_coeff_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, coeff_reg} < modulus_reg))
        else $error("coefficient not below modulus");

    // the last coefficient of a run sits at index want-1
    a_final_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && final_reg) |-> ({1'b0, index_reg} + 11'd1 == want))
        else $error("final_res at wrong index");

    // group position stays inside a nine-byte group
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.group_position <= GROUP_LAST)
        else $error("group position out of range");

    // a stalled result register with a waiting byte blocks the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while pipeline is blocked");

endmodule

`default_nettype wire

@@ hw/rtl/nbrs_step.sv @@
// Per-byte sampling step: group tracking, candidate forming, compare
// against the modulus and count update. Depends on nbrs_pkg.
`default_nettype none

module nbrs_step
    import nbrs_pkg::*;
(
    input  sampler_state_t        state,
    input  logic [BYTE_W-1:0]     rand_byte,
    input  logic                  restart,
    input  logic [MODULUS_W-1:0]  modulus,
    input  logic [COUNT_W-1:0]    want,
    output sampler_state_t        state_next,
    output sample_result_t        res
);

    sampler_state_t     cur;
    logic [2:0]         bit_sel;
    logic [COEFF_W-1:0] cand;
    logic [COUNT_W-1:0] count_inc;

    always_comb
    begin
        cur = restart ? '0 : state;
        state_next = cur;
        res = '0;
        bit_sel = 3'(cur.group_position - 4'd1);
        cand = {rand_byte, cur.low_bit_byte[bit_sel]};
        count_inc = cur.accepted_count + 11'd1;

        // run complete: byte is dropped with no state change
        if (cur.accepted_count < want)
        begin
            if (!(cur.group_position inside {[4'd1:GROUP_LAST]}))
            begin
                state_next.low_bit_byte   = rand_byte;
                state_next.group_position = 4'd1;
            end
            else
            begin
                state_next.group_position = (cur.group_position >= GROUP_LAST) ?
                                            '0 : cur.group_position + 4'd1;
                if ({1'b0, cand} < modulus)
                begin
                    res.valid       = 1'b1;
                    res.coefficient = cand;
                    res.coeff_index = cur.accepted_count[INDEX_W-1:0];
                    res.final_res   = (count_inc == want);
                    state_next.accepted_count = count_inc;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/coeff_stream_checker.sv @@
// Checker for the nine-byte rejection sampler: watches the byte and coefficient
// channels and the register port, predicts every coefficient and compares.
// Depends on nbrs_pkg and the channel interfaces in nbrs_if.
module coeff_stream_checker
    import nbrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    nbrs_in_if                      in_mon,
    nbrs_out_if                     out_mon,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic [31:0]        prdata,
    output int                      errors,
    output int                      outstanding
);

    typedef struct packed {
        logic [COEFF_W-1:0] coefficient;
        logic [INDEX_W-1:0] coeff_index;
        logic               final_res;
    } coeff_t;

    coeff_t               pending_coeffs[$];

    // Shadow registers and sampler state
    logic [MODULUS_W-1:0] modulus;
    logic [COUNT_W-1:0]   wanted;
    logic [BYTE_W-1:0]    low_bits;
    logic [POS_W-1:0]     position;
    logic [COUNT_W-1:0]   produced;

    // Advance the shadow sampler by one byte; queue the coefficient it yields.
    task automatic take_byte(input logic [BYTE_W-1:0] b, input logic r);
        logic [COUNT_W-1:0] limit;
        logic [COEFF_W-1:0] cand;
        coeff_t             c;
        if (r)
        begin
            position = '0;
            produced = '0;
            low_bits = '0;
        end
        limit = (wanted > COUNT_W'(MAX_COEFFS)) ? COUNT_W'(MAX_COEFFS) : wanted;
        if (produced >= limit)
            return;
        if (position == '0 || position > GROUP_LAST)
        begin
            low_bits = b;
            position = POS_W'(1);
            return;
        end
        cand     = {b, low_bits[3'(position - POS_W'(1))]};
        position = (position >= GROUP_LAST) ? '0 : position + POS_W'(1);
        if (MODULUS_W'(cand) >= modulus)
            return;
        c.coefficient = cand;
        c.coeff_index = produced[INDEX_W-1:0];
        produced      = produced + COUNT_W'(1);
        c.final_res   = (produced == limit);
        pending_coeffs.push_back(c);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        coeff_t      got;
        coeff_t      want_c;
        logic [31:0] want_rd;
        if (!rst_n)
        begin
            modulus     = MODULUS_RESET;
            wanted      = WANTED_RESET;
            low_bits    = '0;
            position    = '0;
            produced    = '0;
            errors      = 0;
            pending_coeffs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got = {out_mon.coefficient, out_mon.coeff_index, out_mon.final_res};
                if (pending_coeffs.size() == 0)
                begin
                    if (errors < 10)
                        $display("ERROR: unexpected coefficient %0d index %0d final %0d",
                                 got.coefficient, got.coeff_index, got.final_res);
                    errors = errors + 1;
                end
                else
                begin
                    want_c = pending_coeffs.pop_front();
                    if (got != want_c)
                    begin
                        if (errors < 10)
                            $display("ERROR: coeff exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     want_c.coefficient, want_c.coeff_index,
                                     want_c.final_res, got.coefficient,
                                     got.coeff_index, got.final_res);
                        errors = errors + 1;
                    end
                end
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (reg_index_t'(paddr[2]))
                        REG_MODULUS: modulus = pwdata[MODULUS_W-1:0];
                        REG_WANTED:  wanted  = pwdata[COUNT_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    want_rd = (reg_index_t'(paddr[2]) == REG_MODULUS) ?
                              32'(modulus) : 32'(wanted);
                    if (prdata !== want_rd)
                    begin
                        if (errors < 10)
                            $display("ERROR: read addr %0d exp %0d got %0d",
                                     paddr, want_rd, prdata);
                        errors = errors + 1;
                    end
                end
            end

            if (in_mon.valid && in_mon.ready)
                take_byte(in_mon.rand_byte, in_mon.restart);

            outstanding <= pending_coeffs.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the sampler testbench: clock, reset, byte stimulus, receiver stalls,
// register programming and the verdict. Depends on nbrs_pkg, nbrs_if,
// nine_bit_rejection_sampler and coeff_stream_checker.
module tb;
    import nbrs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;  // far above any correct run
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 4;       // two-stage pipeline plus margin
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_PHASE    = 2;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } stall_mode_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors;
    int                 outstanding;
    logic               hold_req;   // set by stimulus, cleared by receiver
    int                 burst_left;

    nbrs_in_if  in_ch();
    nbrs_out_if out_ch();

    nine_bit_rejection_sampler dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    coeff_stream_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte from the next falling edge until a transfer happens.
    // valid stays high across back-to-back transfers.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic r);
        @(negedge clk);
        in_ch.valid     = 1'b1;
        in_ch.rand_byte = b;
        in_ch.restart   = r;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid for an idle gap of length n; n of zero keeps the burst going.
    task automatic idle_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Setup cycle, then access cycle; pready is sampled at the rising edge.
    task automatic apb_access(input logic write, input reg_index_t idx,
                              input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Stop sending and wait until every predicted coefficient has been taken,
    // then give trailing bytes with no result time to leave the pipeline.
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers change only with the block idle; read-back is checked by chk.
    task automatic program_regs(input logic [31:0] modulus, input logic [31:0] wanted);
        settle();
        apb_access(1'b1, REG_MODULUS, modulus);
        apb_access(1'b1, REG_WANTED, wanted);
        apb_access(1'b0, REG_MODULUS, '0);
        apb_access(1'b0, REG_WANTED, '0);
    endtask

    // Receiver: each stall pattern runs for a random stretch before a new one is drawn;
    // a hold request parks ready low for a long stretch so the input side backs up.
    initial
    begin : receiver
        stall_mode_t mode;
        int          left;
        out_ch.ready = 1'b0;
        mode         = RX_ALWAYS;
        left         = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 200);
                end
                left = left - 1;
                case (mode)
                    RX_ALWAYS:   out_ch.ready = 1'b1;
                    RX_COIN:     out_ch.ready = 1'($urandom_range(0, 1));
                    RX_MOSTLY:   out_ch.ready = ($urandom_range(0, 9) != 0);
                    RX_PERIODIC: out_ch.ready = ((left % 16) >= 5);
                    default:     out_ch.ready = 1'b1;
                endcase
            end
        end
    end

    // Cycle watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] modulus;
        logic [31:0] wanted;
        int          restart_odds;

        in_ch.valid     = 1'b0;
        in_ch.rand_byte = '0;
        in_ch.restart   = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        hold_req        = 1'b0;
        burst_left      = 0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values read back before anything is written
        apb_access(1'b0, REG_MODULUS, '0);
        apb_access(1'b0, REG_WANTED, '0);

        // Reset config: every candidate below 512, full group of extremes
        send_byte(8'hA5, 1'b1);
        send_byte(8'hFF, 1'b0);     // 511, largest candidate
        send_byte(8'h00, 1'b0);     // 0
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h3C, 1'b0);     // opens next group
        send_byte(8'h12, 1'b0);
        send_byte(8'hC3, 1'b1);     // restart in the middle of a group
        send_byte(8'h00, 1'b0);

        // Modulus 1 with an oversized wanted count: only candidate 0 passes
        program_regs(32'd1, 32'd2047);
        send_byte(8'h0F, 1'b1);
        repeat (8) send_byte(8'h00, 1'b0);

        // Modulus 0 rejects everything
        program_regs(32'd0, 32'd1024);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);

        // Modulus above 512 takes all; the run completes after three and
        // the following byte is ignored
        program_regs(32'd1023, 32'd3);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h40, 1'b0);

        // Wanted count of zero never emits
        program_regs(32'd513, 32'd0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);

        // Random phases: new settings each time, taken without a forced
        // restart so a lowered count can end a run in progress
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 5))
                0:       modulus = 32'd512;
                1:       modulus = 32'd1;
                2:       modulus = 32'd1023;
                3:       modulus = $urandom_range(256, 512);
                4:       modulus = $urandom_range(0, 1023);
                default: modulus = $urandom_range(400, 512);
            endcase
            case ($urandom_range(0, 4))
                0:       wanted = $urandom_range(1, 16);
                1:       wanted = $urandom_range(17, 200);
                2:       wanted = 32'd1024;
                3:       wanted = 32'd2047;
                default: wanted = $urandom_range(1, 2047);
            endcase
            // Last phase pins modulus to 512 and the wanted count to 1
            if (p == RANDOM_PHASES - 1)
            begin
                modulus = 32'd512;
                wanted  = 32'd1;
            end
            restart_odds = $urandom_range(8, 120);
            program_regs(modulus, wanted);

            // Receiver parks while the sender keeps offering
            if (p == HOLD_PHASE)
                hold_req = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (burst_left == 0)
                begin
                    idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left = burst_left - 1;
                send_byte(8'($urandom_range(0, 255)),
                          $urandom_range(0, restart_odds) == 0);
            end
        end

        settle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
